// ===== rtl/lpcs_pkg.sv =====
// Shared constants and types of the LCD pixel command sequencer.
package lpcs_pkg;

  // Default coordinate arithmetic width
  localparam int COORD_WIDTH_DEF = 8;

  // Configuration port address width: seven 32-bit registers at 4*i
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Link command bytes
  localparam logic [7:0] CMD_COL     = 8'h2A;
  localparam logic [7:0] CMD_ROW     = 8'h2B;
  localparam logic [7:0] CMD_MEM     = 8'h2C;
  localparam logic [7:0] CMD_VSCROLL = 8'h37;
  localparam logic [7:0] BYTE_ZERO   = 8'h00;

  // Input item kinds
  localparam logic MODE_PIXEL  = 1'b0;
  localparam logic MODE_SCROLL = 1'b1;

  // Last byte position of each sequence
  localparam logic [3:0] SEQ_PIXEL_LAST  = 4'd12;
  localparam logic [3:0] SEQ_SCROLL_LAST = 4'd2;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ORIENTATION  = 3'd0,
    REG_PANEL_WIDTH  = 3'd1,
    REG_PANEL_HEIGHT = 3'd2,
    REG_RAM_WIDTH    = 3'd3,
    REG_RAM_HEIGHT   = 3'd4,
    REG_OFFSET_X     = 3'd5,
    REG_OFFSET_Y     = 3'd6
  } reg_idx_t;

  // Display rotation
  typedef enum logic [1:0] {
    ORIENT_UP    = 2'd0,
    ORIENT_DOWN  = 2'd1,
    ORIENT_LEFT  = 2'd2,
    ORIENT_RIGHT = 2'd3
  } orient_t;

endpackage

// ===== rtl/lpcs_in_if.sv =====
// Input channel of the LCD pixel command sequencer.
interface lpcs_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  pos_x;
  logic [7:0]  pos_y;
  logic [15:0] pixel_color;
  logic signed [8:0] scroll_rows;

  modport source (output valid, mode, pos_x, pos_y, pixel_color, scroll_rows,
                  input ready);
  modport sink (input valid, mode, pos_x, pos_y, pixel_color, scroll_rows,
                output ready);
endinterface

// ===== rtl/lpcs_out_if.sv =====
// Result channel of the LCD pixel command sequencer.
interface lpcs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] link_byte;
  logic       is_command;
  logic       last;

  modport source (output valid, link_byte, is_command, last, input ready);
  modport sink (input valid, link_byte, is_command, last, output ready);
endinterface

// ===== rtl/lcd_pixel_command_sequencer.sv =====
// Top level: maps pixel writes and scrolls to a stream of TFT link bytes.
// An accepted item passes the input register, then the serializer register, before
// its byte stream starts. Bytes flow one per cycle while the receiver is ready:
// 13 for a pixel write, 3 for a scroll; the byte serializer sets the rate. The input
// register takes the next item while the current one streams. Synchronous active-low
// reset restores the register defaults, clears the scroll row and empties both stages.
module lcd_pixel_command_sequencer #(
  parameter int COORD_WIDTH = lpcs_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lpcs_in_if.sink                         in_chan,
  lpcs_out_if.source                      out_chan,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lpcs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [lpcs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [lpcs_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import lpcs_pkg::*;

  localparam int CW = COORD_WIDTH;

  // Configuration registers
  orient_t    orientation_r;
  logic [7:0] panel_width_r, panel_height_r, ram_width_r, ram_height_r;
  logic [7:0] offset_x_r, offset_y_r;
  logic [7:0] first_row_r, first_row_nxt;

  // Input stage
  logic              s1_valid_r;
  logic              s1_mode_r;
  logic [7:0]        s1_pos_x_r, s1_pos_y_r;
  logic [15:0]       s1_color_r;
  logic signed [8:0] s1_rows_r;

  // Serializer stage
  logic        s2_valid_r;
  logic        s2_scroll_r;
  logic [3:0]  s2_idx_r;
  logic [7:0]  s2_x_r, s2_y_r, s2_sbyte_r;
  logic [15:0] s2_color_r;

  logic       cfg_wr;
  reg_idx_t   cfg_idx;
  logic       s2_last, s2_done, s1_move;
  logic [7:0] pix_x_nxt, pix_y_nxt, sbyte_nxt;

  // Configuration port: writes complete in the access phase, no wait states
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orientation_r  <= ORIENT_UP;
      panel_width_r  <= 8'd128;
      panel_height_r <= 8'd160;
      ram_width_r    <= 8'd132;
      ram_height_r   <= 8'd162;
      offset_x_r     <= 8'd2;
      offset_y_r     <= 8'd1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ORIENTATION:  orientation_r  <= orient_t'(pwdata[1:0]);
        REG_PANEL_WIDTH:  panel_width_r  <= pwdata[7:0];
        REG_PANEL_HEIGHT: panel_height_r <= pwdata[7:0];
        REG_RAM_WIDTH:    ram_width_r    <= pwdata[7:0];
        REG_RAM_HEIGHT:   ram_height_r   <= pwdata[7:0];
        REG_OFFSET_X:     offset_x_r     <= pwdata[7:0];
        REG_OFFSET_Y:     offset_y_r     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_ORIENTATION:  prdata[1:0] = orientation_r;
      REG_PANEL_WIDTH:  prdata[7:0] = panel_width_r;
      REG_PANEL_HEIGHT: prdata[7:0] = panel_height_r;
      REG_RAM_WIDTH:    prdata[7:0] = ram_width_r;
      REG_RAM_HEIGHT:   prdata[7:0] = ram_height_r;
      REG_OFFSET_X:     prdata[7:0] = offset_x_r;
      REG_OFFSET_Y:     prdata[7:0] = offset_y_r;
      default:          prdata      = '0;
    endcase
  end

  // Handshake between the stages
  assign s2_last = s2_scroll_r ? (s2_idx_r == SEQ_SCROLL_LAST)
                               : (s2_idx_r == SEQ_PIXEL_LAST);
  assign s2_done = s2_valid_r && out_chan.ready && s2_last;
  assign s1_move = s1_valid_r && (!s2_valid_r || s2_done);
  assign in_chan.ready = !s1_valid_r || s1_move;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_mode_r  <= in_chan.mode;
      s1_pos_x_r <= in_chan.pos_x;
      s1_pos_y_r <= in_chan.pos_y;
      s1_color_r <= in_chan.pixel_color;
      s1_rows_r  <= in_chan.scroll_rows;
    end
  end

  // Pixel coordinate mapping, modulo 2^CW
  logic [CW-1:0] ph_w, pw_w, rw_w, rh_w, ox_w, oy_w, fr_w;
  logic [CW-1:0] top_w, xa, ya, xw, yw, rx_w, ry_w, xf, yf;

  always_comb begin
    ph_w  = CW'(panel_height_r);
    pw_w  = CW'(panel_width_r);
    rw_w  = CW'(ram_width_r);
    rh_w  = CW'(ram_height_r);
    ox_w  = CW'(offset_x_r);
    oy_w  = CW'(offset_y_r);
    fr_w  = CW'(first_row_r);
    top_w = ph_w + oy_w - fr_w - CW'(1);
    rx_w  = rw_w - pw_w - ox_w;
    ry_w  = rh_w - ph_w - oy_w;
    xa    = CW'(s1_pos_x_r);
    ya    = CW'(s1_pos_y_r);
    // Rotate and apply the scroll row
    case (orientation_r)
      ORIENT_UP:    ya = ya + top_w;
      ORIENT_DOWN:  ya = ya + fr_w;
      ORIENT_LEFT:  xa = xa + top_w;
      default:      xa = xa + fr_w;
    endcase
    // One conditional wrap by the panel height
    xw = (xa >= ph_w) ? xa - ph_w : xa;
    yw = (ya >= ph_w) ? ya - ph_w : ya;
    // Frame memory offsets
    case (orientation_r)
      ORIENT_UP: begin
        xf = xw + rx_w;
        yf = yw + ry_w;
      end
      ORIENT_DOWN: begin
        xf = xw + ox_w;
        yf = yw + oy_w;
      end
      ORIENT_LEFT: begin
        xf = xw + ry_w;
        yf = yw + ox_w;
      end
      default: begin
        xf = xw + oy_w;
        yf = yw + rx_w;
      end
    endcase
    pix_x_nxt = xf[7:0];
    pix_y_nxt = yf[7:0];
  end

  // Scroll row update with one wrap into the panel height
  logic signed [9:0] ssum, sh;

  always_comb begin
    sh   = signed'({2'b00, panel_height_r});
    ssum = signed'({2'b00, first_row_r}) + 10'(s1_rows_r);
    if (ssum < 0) begin
      ssum = ssum + sh;
    end else if (ssum >= sh) begin
      ssum = ssum - sh;
    end
    first_row_nxt = ssum[7:0];
    sbyte_nxt     = offset_y_r + first_row_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_row_r <= 8'd0;
    end else if (s1_move && (s1_mode_r == MODE_SCROLL)) begin
      first_row_r <= first_row_nxt;
    end
  end

  // Serializer stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s2_idx_r   <= 4'd0;
    end else if (s1_move) begin
      s2_valid_r <= 1'b1;
      s2_idx_r   <= 4'd0;
    end else if (s2_done) begin
      s2_valid_r <= 1'b0;
    end else if (s2_valid_r && out_chan.ready) begin
      s2_idx_r <= s2_idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_scroll_r <= (s1_mode_r == MODE_SCROLL);
      s2_x_r      <= pix_x_nxt;
      s2_y_r      <= pix_y_nxt;
      s2_color_r  <= s1_color_r;
      s2_sbyte_r  <= sbyte_nxt;
    end
  end

  // Byte selection for the current position of the sequence
  always_comb begin
    out_chan.link_byte  = BYTE_ZERO;
    out_chan.is_command = 1'b0;
    if (s2_scroll_r) begin
      case (s2_idx_r)
        4'd0: begin
          out_chan.link_byte  = CMD_VSCROLL;
          out_chan.is_command = 1'b1;
        end
        4'd2:    out_chan.link_byte = s2_sbyte_r;
        default: out_chan.link_byte = BYTE_ZERO;
      endcase
    end else begin
      case (s2_idx_r)
        4'd0: begin
          out_chan.link_byte  = CMD_COL;
          out_chan.is_command = 1'b1;
        end
        4'd2, 4'd4: out_chan.link_byte = s2_x_r;
        4'd5: begin
          out_chan.link_byte  = CMD_ROW;
          out_chan.is_command = 1'b1;
        end
        4'd7, 4'd9: out_chan.link_byte = s2_y_r;
        4'd10: begin
          out_chan.link_byte  = CMD_MEM;
          out_chan.is_command = 1'b1;
        end
        4'd11:   out_chan.link_byte = s2_color_r[15:8];
        4'd12:   out_chan.link_byte = s2_color_r[7:0];
        default: out_chan.link_byte = BYTE_ZERO;
      endcase
    end
  end

  assign out_chan.valid = s2_valid_r;
  assign out_chan.last  = s2_last;

endmodule

// ===== tb/link_byte_checker.sv =====
// Link byte checker: tracks configuration writes, predicts each item's link bytes and compares.
module link_byte_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  lpcs_in_if                              in_mon,
  lpcs_out_if                             out_mon,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [lpcs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [lpcs_pkg::CFG_DATA_W-1:0] pwdata,
  output int                              mismatch_count,
  output int                              bytes_pending
);
  import lpcs_pkg::*;

  // Register values after reset.
  localparam logic [7:0] PANEL_W_INIT = 8'd128;
  localparam logic [7:0] PANEL_H_INIT = 8'd160;
  localparam logic [7:0] RAM_W_INIT   = 8'd132;
  localparam logic [7:0] RAM_H_INIT   = 8'd162;
  localparam logic [7:0] OFS_X_INIT   = 8'd2;
  localparam logic [7:0] OFS_Y_INIT   = 8'd1;

  typedef struct packed {
    logic [7:0] link_byte;
    logic       is_command;
    logic       last;
  } link_byte_t;

  link_byte_t expected_bytes[$];
  int         mismatches = 0;

  // Shadow copy of the configuration and the kept scroll row.
  orient_t    rot;
  logic [7:0] panel_w, panel_h, ram_w, ram_h, ofs_x, ofs_y;
  logic [7:0] scroll_row;

  function automatic void expect_byte(input logic [7:0] b, input logic cmd, input logic lst);
    link_byte_t e;
    e.link_byte  = b;
    e.is_command = cmd;
    e.last       = lst;
    expected_bytes.push_back(e);
  endfunction

  function automatic void apply_register(input logic [CFG_ADDR_W-1:0] addr,
                                         input logic [CFG_DATA_W-1:0] data);
    case (addr[CFG_ADDR_W-1:2])
      REG_ORIENTATION:  rot = orient_t'(data[1:0]);
      REG_PANEL_WIDTH:  panel_w = data[7:0];
      REG_PANEL_HEIGHT: panel_h = data[7:0];
      REG_RAM_WIDTH:    ram_w = data[7:0];
      REG_RAM_HEIGHT:   ram_h = data[7:0];
      REG_OFFSET_X:     ofs_x = data[7:0];
      REG_OFFSET_Y:     ofs_y = data[7:0];
      default: ;
    endcase
  endfunction

  // Scroll: one wrap into the panel height, then the vertical scroll start sequence.
  function automatic void predict_scroll(input logic signed [8:0] rows);
    int         sum;
    logic [7:0] start_row;
    sum = int'(scroll_row) + int'(rows);
    if (sum < 0) begin
      sum = sum + int'(panel_h);
    end else if (sum >= int'(panel_h)) begin
      sum = sum - int'(panel_h);
    end
    scroll_row = sum[7:0];
    start_row  = ofs_y + scroll_row;
    expect_byte(CMD_VSCROLL, 1'b1, 1'b0);
    expect_byte(BYTE_ZERO, 1'b0, 1'b0);
    expect_byte(start_row, 1'b0, 1'b1);
  endfunction

  // Pixel write: rotate, shift by the scroll row, wrap once, add the RAM offsets.
  function automatic void predict_pixel(input logic [7:0] px, input logic [7:0] py,
                                        input logic [15:0] color);
    logic [7:0] x, y, top, col_pad, row_pad;
    x   = px;
    y   = py;
    top = panel_h + ofs_y - scroll_row - 8'd1;
    case (rot)
      ORIENT_UP:   y = y + top;
      ORIENT_DOWN: y = y + scroll_row;
      ORIENT_LEFT: x = x + top;
      default:     x = x + scroll_row;
    endcase
    if (y >= panel_h) begin
      y = y - panel_h;
    end
    if (x >= panel_h) begin
      x = x - panel_h;
    end
    col_pad = ram_w - panel_w - ofs_x;
    row_pad = ram_h - panel_h - ofs_y;
    case (rot)
      ORIENT_UP: begin
        x = x + col_pad;
        y = y + row_pad;
      end
      ORIENT_DOWN: begin
        x = x + ofs_x;
        y = y + ofs_y;
      end
      ORIENT_LEFT: begin
        x = x + row_pad;
        y = y + ofs_x;
      end
      default: begin
        x = x + ofs_y;
        y = y + col_pad;
      end
    endcase
    expect_byte(CMD_COL, 1'b1, 1'b0);
    expect_byte(BYTE_ZERO, 1'b0, 1'b0);
    expect_byte(x, 1'b0, 1'b0);
    expect_byte(BYTE_ZERO, 1'b0, 1'b0);
    expect_byte(x, 1'b0, 1'b0);
    expect_byte(CMD_ROW, 1'b1, 1'b0);
    expect_byte(BYTE_ZERO, 1'b0, 1'b0);
    expect_byte(y, 1'b0, 1'b0);
    expect_byte(BYTE_ZERO, 1'b0, 1'b0);
    expect_byte(y, 1'b0, 1'b0);
    expect_byte(CMD_MEM, 1'b1, 1'b0);
    expect_byte(color[15:8], 1'b0, 1'b0);
    expect_byte(color[7:0], 1'b0, 1'b1);
  endfunction

  // Compare one accepted byte with the oldest expectation.
  function automatic void check_link_byte(input logic [7:0] b, input logic cmd,
                                          input logic lst);
    link_byte_t e;
    if (expected_bytes.size() == 0) begin
      mismatches++;
      $display("%0t: link byte %02h cmd %0b last %0b arrived with nothing expected",
               $time, b, cmd, lst);
    end else begin
      e = expected_bytes.pop_front();
      if (b !== e.link_byte || cmd !== e.is_command || lst !== e.last) begin
        mismatches++;
        $display("%0t: link byte mismatch: expected %02h cmd %0b last %0b, got %02h cmd %0b last %0b",
                 $time, e.link_byte, e.is_command, e.last, b, cmd, lst);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      rot        = ORIENT_UP;
      panel_w    = PANEL_W_INIT;
      panel_h    = PANEL_H_INIT;
      ram_w      = RAM_W_INIT;
      ram_h      = RAM_H_INIT;
      ofs_x      = OFS_X_INIT;
      ofs_y      = OFS_Y_INIT;
      scroll_row = 8'd0;
      expected_bytes.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        apply_register(paddr, pwdata);
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.mode == MODE_SCROLL) begin
          predict_scroll(in_mon.scroll_rows);
        end else begin
          predict_pixel(in_mon.pos_x, in_mon.pos_y, in_mon.pixel_color);
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        check_link_byte(out_mon.link_byte, out_mon.is_command, out_mon.last);
      end
    end
    bytes_pending  <= expected_bytes.size();
    mismatch_count <= mismatches;
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: clock, reset, configuration writes, item stimulus and the verdict.
module tb_top;
  import lpcs_pkg::*;

  localparam int             HOLD_CYCLES   = 200;
  localparam int             QUIET_LIMIT   = 2000;
  localparam int             PHASES        = 9;
  localparam int             PHASE_ITEMS   = 45;
  localparam logic [2:0]     IDX_UNMAPPED  = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  psel, penable, pwrite, pready;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata, prdata;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_request = 1'b0;
  logic hold_done;
  int   mismatch_count;
  int   bytes_pending;

  lpcs_in_if  in_bus ();
  lpcs_out_if out_bus ();

  lcd_pixel_command_sequencer DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  link_byte_checker link_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_bus),
    .out_mon        (out_bus),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_count (mismatch_count),
    .bytes_pending  (bytes_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // One register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offer one item after a random gap and wait for it to be taken.
  task automatic send_item(input logic mode, input logic [7:0] x, input logic [7:0] y,
                           input logic [15:0] color, input logic signed [8:0] rows);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.mode        <= mode;
    in_bus.pos_x       <= x;
    in_bus.pos_y       <= y;
    in_bus.pixel_color <= color;
    in_bus.scroll_rows <= rows;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Stop offering and wait until every predicted byte has come out.
  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (bytes_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input int style);
    logic [CFG_DATA_W-1:0] v;
    case (style)
      0: v = $urandom_range(1, 255);
      1: begin
        case ($urandom_range(0, 3))
          0:       v = 0;
          1:       v = 1;
          2:       v = 254;
          default: v = 255;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic signed [8:0] pick_rows();
    logic signed [8:0] r;
    if ($urandom_range(0, 1) == 0) begin
      r = 9'($urandom);
    end else begin
      r = 9'($urandom_range(0, 16)) - 9'sd8;
    end
    return r;
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    hold_done = 1'b0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no transfer anywhere.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (psel && penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    orient_t turns[3];
    logic    mode;
    int      style;

    turns[0] = ORIENT_DOWN;
    turns[1] = ORIENT_LEFT;
    turns[2] = ORIENT_RIGHT;

    rst_n              <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_bus.valid       <= 1'b0;
    in_bus.mode        <= MODE_PIXEL;
    in_bus.pos_x       <= '0;
    in_bus.pos_y       <= '0;
    in_bus.pixel_color <= '0;
    in_bus.scroll_rows <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items at the reset configuration: field extremes, ignored fields,
    // wraps on both sides and a row count of -256.
    send_item(MODE_PIXEL, 8'd0, 8'd0, 16'h0000, 9'h000);
    send_item(MODE_PIXEL, 8'd255, 8'd255, 16'hFFFF, 9'h1FF);
    send_item(MODE_PIXEL, 8'h55, 8'hAA, 16'h5AA5, 9'h100);
    send_item(MODE_PIXEL, 8'd159, 8'd127, 16'h8001, 9'h0AA);
    send_item(MODE_PIXEL, 8'd160, 8'd160, 16'h7FFE, 9'h055);
    send_item(MODE_SCROLL, 8'hFF, 8'hFF, 16'hFFFF, 9'h001);
    send_item(MODE_SCROLL, 8'h00, 8'h00, 16'h0000, 9'h0FF);
    send_item(MODE_SCROLL, 8'hA5, 8'h5A, 16'h1234, -9'sd255);
    // Sum stays negative after one wrap, so the row is kept out of range.
    send_item(MODE_SCROLL, 8'h00, 8'hFF, 16'hFF00, 9'h100);
    send_item(MODE_PIXEL, 8'd10, 8'd20, 16'hF81F, 9'h000);
    send_item(MODE_SCROLL, 8'h3C, 8'hC3, 16'h00FF, 9'h000);

    // Every orientation other than the reset one, once each.
    foreach (turns[i]) begin
      drain();
      write_reg(REG_ORIENTATION, {30'd0, turns[i]});
      send_item(MODE_PIXEL, 8'd0, 8'd0, 16'hAAAA, 9'h000);
      send_item(MODE_PIXEL, 8'd255, 8'd200, 16'h5555, 9'h1AB);
    end

    // Zero panel height leaves both wraps without effect.
    drain();
    write_reg(REG_PANEL_HEIGHT, 32'd0);
    send_item(MODE_PIXEL, 8'd200, 8'd100, 16'hC3C3, 9'h000);
    send_item(MODE_SCROLL, 8'd0, 8'd0, 16'h0000, -9'sd5);
    send_item(MODE_SCROLL, 8'd0, 8'd0, 16'h0000, 9'sd7);

    // A write beyond the last register changes nothing.
    drain();
    write_reg(IDX_UNMAPPED, 32'hFFFF_FFFF);
    send_item(MODE_PIXEL, 8'd33, 8'd66, 16'h0F0F, 9'h000);

    // Random phases, each with a fresh configuration.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p / 3)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 53;
        end
        1: begin
          send_idle_pct = 53;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      style = p % 3;
      write_reg(REG_ORIENTATION, {30'($urandom), 2'(p % 4)});
      write_reg(REG_PANEL_WIDTH, pick_reg_value(style));
      write_reg(REG_PANEL_HEIGHT, pick_reg_value(style));
      write_reg(REG_RAM_WIDTH, pick_reg_value(style));
      write_reg(REG_RAM_HEIGHT, pick_reg_value(style));
      write_reg(REG_OFFSET_X, pick_reg_value(style));
      write_reg(REG_OFFSET_Y, pick_reg_value(style));
      // The long receiver hold-off lands at the start of the first random phase.
      if (p == 0) begin
        hold_request = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        mode = ($urandom_range(99) < 30) ? MODE_SCROLL : MODE_PIXEL;
        send_item(mode, 8'($urandom), 8'($urandom), 16'($urandom), pick_rows());
      end
    end

    drain();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
